// ===== hdl/bdq_pkg.sv =====
// shared types and codes for the byte deque with purge
package bdq_pkg;

	localparam int KIND_W    = 3;
	localparam int VAL_W     = 8;
	localparam int STAT_W    = 2;
	localparam int CNT_W     = 9;
	localparam int M_TDATA_W = 24;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH_FRONT = 3'd0,
		KIND_PUSH_BACK  = 3'd1,
		KIND_POP_FRONT  = 3'd2,
		KIND_POP_BACK   = 3'd3,
		KIND_PURGE      = 3'd4,
		KIND_SIZE       = 3'd5
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_PURGE
	} state_t;

endpackage

// ===== hdl/byte_deque_with_purge.sv =====
// byte deque in a ring memory with in-place purge compaction
//
//  channel  dir  tdata (low bit up)                        tuser
//  s_*      in   value[7:0]                                kind[2:0]
//  m_*      out  data[7:0], count[16:8], zero pad [23:17]  status[1:0]
//
// push and size are handled in the accepting cycle; pop waits on the registered memory read
// purge: one entry read and compacted per cycle over the single read and single
//   write port of the ring memory
// reset clears front index, occupancy and the output beat; memory is not cleared
// s_tready is low while a pop or purge is in flight, or while a beat waits
//   on m_tready and the output register cannot drain
module byte_deque_with_purge #(
	parameter int DEPTH = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [bdq_pkg::VAL_W-1:0]    s_tdata,   // value[7:0]
	input  logic [bdq_pkg::KIND_W-1:0]   s_tuser,   // kind[2:0]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [bdq_pkg::M_TDATA_W-1:0] m_tdata,  // data[7:0], count[16:8], zero[23:17]
	output logic [bdq_pkg::STAT_W-1:0]   m_tuser    // status[1:0]
);
	import bdq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int OW = $clog2(DEPTH + 1);
	localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);
	localparam int PAD_W = M_TDATA_W - VAL_W - CNT_W;

	function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
	                                       input logic [AW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= DEPTH_W) begin
			sum = sum - DEPTH_W;
		end
		return sum[AW-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] to_count(input logic [OW-1:0] x);
		logic [OW+CNT_W-1:0] ext;
		ext = {{CNT_W{1'b0}}, x};
		return ext[CNT_W-1:0];
	endfunction

	logic [VAL_W-1:0] mem [DEPTH];

	state_t state_q, state_d;
	logic [AW-1:0] front_q, front_d;
	logic [OW-1:0] occ_q, occ_d;
	logic [OW-1:0] rd_off_q, rd_off_d;
	logic [OW-1:0] kept_q, kept_d;
	logic [VAL_W-1:0] pval_q, pval_d;
	logic pvld_s1, pvld_d;
	logic [VAL_W-1:0] rd_data_s1;

	logic rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [VAL_W-1:0] wr_data;

	logic out_vld_q;
	status_t out_status_q, out_status_d;
	logic [VAL_W-1:0] out_data_q, out_data_d;
	logic [CNT_W-1:0] out_count_q, out_count_d;
	logic out_load;

	logic acc, full, empty, rd_more;
	logic [OW-1:0] occ_m1;

	assign full    = (occ_q == OW'(DEPTH));
	assign empty   = (occ_q == '0);
	assign occ_m1  = occ_q - OW'(1);
	assign rd_more = (rd_off_q != occ_q);

	assign s_tready = (state_q == ST_IDLE) && (!out_vld_q || m_tready);
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		state_d      = state_q;
		front_d      = front_q;
		occ_d        = occ_q;
		rd_off_d     = rd_off_q;
		kept_d       = kept_q;
		pval_d       = pval_q;
		pvld_d       = 1'b0;
		rd_en        = 1'b0;
		rd_addr      = front_q;
		wr_en        = 1'b0;
		wr_addr      = front_q;
		wr_data      = s_tdata;
		out_load     = 1'b0;
		out_status_d = STAT_OK;
		out_data_d   = '0;
		out_count_d  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (s_tuser)
						KIND_PUSH_FRONT: begin
							if (full) begin
								out_load     = 1'b1;
								out_status_d = STAT_FULL;
							end else begin
								front_d = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
								wr_en   = 1'b1;
								wr_addr = front_d;
								occ_d   = occ_q + OW'(1);
							end
						end
						KIND_PUSH_BACK: begin
							if (full) begin
								out_load     = 1'b1;
								out_status_d = STAT_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_addr = slot(front_q, occ_q[AW-1:0]);
								occ_d   = occ_q + OW'(1);
							end
						end
						KIND_POP_FRONT: begin
							if (empty) begin
								out_load     = 1'b1;
								out_status_d = STAT_EMPTY;
							end else begin
								rd_en   = 1'b1;
								rd_addr = front_q;
								front_d = slot(front_q, AW'(1));
								occ_d   = occ_m1;
								state_d = ST_POP;
							end
						end
						KIND_POP_BACK: begin
							if (empty) begin
								out_load     = 1'b1;
								out_status_d = STAT_EMPTY;
							end else begin
								rd_en   = 1'b1;
								rd_addr = slot(front_q, occ_m1[AW-1:0]);
								occ_d   = occ_m1;
								state_d = ST_POP;
							end
						end
						KIND_PURGE: begin
							rd_off_d = '0;
							kept_d   = '0;
							pval_d   = s_tdata;
							state_d  = ST_PURGE;
						end
						KIND_SIZE: begin
							out_load    = 1'b1;
							out_count_d = to_count(occ_q);
						end
						default: begin
						end
					endcase
				end
			end
			ST_POP: begin
				out_load   = 1'b1;
				out_data_d = rd_data_s1;
				state_d    = ST_IDLE;
			end
			ST_PURGE: begin
				// reads run one entry ahead of the compare; the write pointer
				// never passes the read pointer, so no forwarding is needed
				if (rd_more) begin
					rd_en    = 1'b1;
					rd_addr  = slot(front_q, rd_off_q[AW-1:0]);
					rd_off_d = rd_off_q + OW'(1);
					pvld_d   = 1'b1;
				end
				if (pvld_s1 && (rd_data_s1 != pval_q)) begin
					wr_en   = 1'b1;
					wr_addr = slot(front_q, kept_q[AW-1:0]);
					wr_data = rd_data_s1;
					kept_d  = kept_q + OW'(1);
				end
				if (!rd_more && !pvld_s1) begin
					out_load    = 1'b1;
					out_data_d  = pval_q;
					out_count_d = to_count(occ_q - kept_q);
					occ_d       = kept_q;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q   <= '0;
			occ_q     <= '0;
			rd_off_q  <= '0;
			kept_q    <= '0;
			pvld_s1   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			front_q  <= front_d;
			occ_q    <= occ_d;
			rd_off_q <= rd_off_d;
			kept_q   <= kept_d;
			pvld_s1  <= pvld_d;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pval_q <= pval_d;
		if (out_load) begin
			out_status_q <= out_status_d;
			out_data_q   <= out_data_d;
			out_count_q  <= out_count_d;
		end
	end

	// ring memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_count_q, out_data_q};
	assign m_tuser  = out_status_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(DEPTH))
		else $error("occupancy beyond depth");

	a_front_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, front_q} < DEPTH_W)
		else $error("front index out of range");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_vld_q || m_tready))
		else $error("result beat overwritten before taken");

	a_purge_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PURGE) |-> (kept_q <= rd_off_q && rd_off_q <= occ_q))
		else $error("purge pointers out of order");

	a_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("read and write hit the same entry");

	a_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |=> (out_vld_q && state_q == ST_IDLE))
		else $error("pop did not produce a beat");

endmodule

// ===== sim/bdq_checker.sv =====
// predictor and result checker for the byte deque, watching both stream channels
`timescale 1ns / 1ps

module bdq_checker #(
	parameter int DEPTH = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [bdq_pkg::VAL_W-1:0]     s_tdata,   // value[7:0]
	input  logic [bdq_pkg::KIND_W-1:0]    s_tuser,   // kind[2:0]
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [bdq_pkg::M_TDATA_W-1:0] m_tdata,   // data[7:0], count[16:8], zero[23:17]
	input  logic [bdq_pkg::STAT_W-1:0]    m_tuser,   // status[1:0]
	output int                            fails,
	output int                            pending,
	output int                            cmds_seen,
	output int                            results_seen,
	output int                            full_drops,
	output int                            empty_pops,
	output int                            bytes_purged
);

	import bdq_pkg::*;

	typedef struct packed {
		status_t            status;
		logic [VAL_W-1:0]   data;
		logic [CNT_W-1:0]   count;
	} result_t;

	logic [VAL_W-1:0] ring [DEPTH];
	int               head;
	int               level;
	result_t          due_results [$];

	int n_bad, n_cmds, n_results, n_full, n_empty, n_purged;

	function automatic int slot(input int offset);
		return (head + offset) % DEPTH;
	endfunction

	task automatic queue_result(input status_t st, input logic [VAL_W-1:0] d,
			input logic [CNT_W-1:0] c);
		result_t r;
		r.status = st;
		r.data   = d;
		r.count  = c;
		due_results = {due_results, r};
	endtask

	task automatic apply_command(input logic [KIND_W-1:0] k, input logic [VAL_W-1:0] v);
		logic [VAL_W-1:0] b;
		int kept;
		kept = 0;
		if (k <= KIND_SIZE)
			n_cmds++;
		case (k)
			KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
				if (level == DEPTH) begin
					n_full++;
					queue_result(STAT_FULL, '0, '0);
				end else if (k == KIND_PUSH_FRONT) begin
					head = slot(DEPTH - 1);
					ring[head] = v;
					level++;
				end else begin
					ring[slot(level)] = v;
					level++;
				end
			end
			KIND_POP_FRONT: begin
				if (level == 0) begin
					n_empty++;
					queue_result(STAT_EMPTY, '0, '0);
				end else begin
					b = ring[head];
					head = slot(1);
					level--;
					queue_result(STAT_OK, b, '0);
				end
			end
			KIND_POP_BACK: begin
				if (level == 0) begin
					n_empty++;
					queue_result(STAT_EMPTY, '0, '0);
				end else begin
					b = ring[slot(level - 1)];
					level--;
					queue_result(STAT_OK, b, '0);
				end
			end
			KIND_PURGE: begin
				// compact survivors toward the front, order kept
				for (int i = 0; i < level; i++) begin
					b = ring[slot(i)];
					if (b != v) begin
						ring[slot(kept)] = b;
						kept++;
					end
				end
				n_purged += level - kept;
				queue_result(STAT_OK, v, CNT_W'(level - kept));
				level = kept;
			end
			KIND_SIZE: queue_result(STAT_OK, '0, CNT_W'(level));
			default: ;
		endcase
	endtask

	task automatic check_result();
		result_t want;
		if (due_results.size() == 0) begin
			n_bad++;
			$display("%0t: unexpected result beat, status %0d data %0h count %0d",
				$time, m_tuser, m_tdata[7:0], m_tdata[16:8]);
		end else begin
			want = due_results[0];
			due_results.delete(0);
			n_results++;
			if (m_tuser !== want.status) begin
				n_bad++;
				$display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
			end
			if (m_tdata[7:0] !== want.data) begin
				n_bad++;
				$display("%0t: data expected %0h actual %0h", $time, want.data, m_tdata[7:0]);
			end
			if (m_tdata[16:8] !== want.count) begin
				n_bad++;
				$display("%0t: count expected %0d actual %0d", $time, want.count,
					m_tdata[16:8]);
			end
			if (m_tdata[23:17] !== '0) begin
				n_bad++;
				$display("%0t: pad bits expected 0 actual %0h", $time, m_tdata[23:17]);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head = 0;
			level = 0;
			due_results.delete();
			n_bad = 0;
			n_cmds = 0;
			n_results = 0;
			n_full = 0;
			n_empty = 0;
			n_purged = 0;
		end else begin
			// a result beat always belongs to an older command than one accepted now
			if (m_tvalid && m_tready)
				check_result();
			if (s_tvalid && s_tready)
				apply_command(s_tuser, s_tdata);
		end
		fails        <= n_bad;
		pending      <= due_results.size();
		cmds_seen    <= n_cmds;
		results_seen <= n_results;
		full_drops   <= n_full;
		empty_pops   <= n_empty;
		bytes_purged <= n_purged;
	end

endmodule

// ===== sim/testbench.sv =====
// stimulus, idling control and verdict for the byte deque with purge
`timescale 1ns / 1ps

module testbench;

	import bdq_pkg::*;

	localparam int DEPTH        = 256;
	localparam int QUIET_LIMIT  = 20000;
	localparam int SETTLE_TICKS = 300;
	localparam int MODE_SPAN    = 40;

	localparam logic [KIND_W-1:0] KIND_UNUSED_A = 3'd6;
	localparam logic [KIND_W-1:0] KIND_UNUSED_B = 3'd7;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [VAL_W-1:0]      s_tdata  = '0;
	logic [KIND_W-1:0]     s_tuser  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [STAT_W-1:0]     m_tuser;

	int fails, pending, cmds_seen, results_seen, full_drops, empty_pops, bytes_purged;
	int send_pct;
	int stall_pct = 0;
	int mode_no = 0;
	int quiet_cycles = 0;

	// a few recurring bytes so purges find plenty of matches
	logic [VAL_W-1:0] hot_bytes [4] = '{8'h00, 8'hFF, 8'h5A, 8'hA5};

	byte_deque_with_purge #(.DEPTH(DEPTH)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	bdq_checker #(.DEPTH(DEPTH)) scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.fails        (fails),
		.pending      (pending),
		.cmds_seen    (cmds_seen),
		.results_seen (results_seen),
		.full_drops   (full_drops),
		.empty_pops   (empty_pops),
		.bytes_purged (bytes_purged)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic set_idling(input int mode);
		case (mode % 4)
			0: begin send_pct = 0;  stall_pct <= 0;  end
			1: begin send_pct = 85; stall_pct <= 0;  end
			2: begin send_pct = 0;  stall_pct <= 85; end
			default: begin send_pct = 32; stall_pct <= 32; end
		endcase
	endtask

	task automatic send_beat(input logic [KIND_W-1:0] k, input logic [VAL_W-1:0] v);
		while ($urandom_range(99) < send_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= v;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic run_directed();
		set_idling(0);
		send_beat(KIND_POP_FRONT, 8'h00);   // empty pops at both ends
		send_beat(KIND_POP_BACK, 8'hFF);
		send_beat(KIND_SIZE, 8'h00);
		send_beat(KIND_PURGE, 8'h33);       // purge of an empty deque
		send_beat(KIND_PUSH_FRONT, 8'h00);  // front push wraps the index below zero
		send_beat(KIND_PUSH_BACK, 8'hFF);
		send_beat(KIND_PUSH_FRONT, 8'h80);
		send_beat(KIND_PUSH_BACK, 8'h7F);
		send_beat(KIND_PUSH_BACK, 8'h01);
		send_beat(KIND_PUSH_FRONT, 8'hFE);
		send_beat(KIND_SIZE, 8'hFF);
		send_beat(KIND_PURGE, 8'h80);       // removes one from the middle
		send_beat(KIND_PURGE, 8'h55);       // nothing matches
		send_beat(KIND_POP_FRONT, 8'h00);
		send_beat(KIND_POP_BACK, 8'h00);
		send_beat(KIND_UNUSED_A, 8'hAA);    // ignored kinds
		send_beat(KIND_UNUSED_B, 8'h55);
		send_beat(KIND_PUSH_BACK, 8'hAA);
		send_beat(KIND_PUSH_BACK, 8'hAA);
		send_beat(KIND_PUSH_FRONT, 8'hAA);
		send_beat(KIND_PURGE, 8'hAA);
		send_beat(KIND_SIZE, 8'h00);
		send_beat(KIND_POP_BACK, 8'h00);
		send_beat(KIND_POP_FRONT, 8'h00);
		send_beat(KIND_POP_FRONT, 8'h00);
		send_beat(KIND_POP_BACK, 8'h00);
	endtask

	task automatic run_mix(input int n, input int w_push, input int w_pop,
			input int w_purge, input int w_size);
		int sent;
		int pick;
		logic [KIND_W-1:0] k;
		logic [VAL_W-1:0] v;
		sent = 0;
		while (sent < n) begin
			if (sent % MODE_SPAN == 0) begin
				set_idling(mode_no);
				mode_no++;
			end
			pick = $urandom_range(w_push + w_pop + w_purge + w_size - 1);
			if ($urandom_range(99) < 3)
				k = $urandom_range(1) ? KIND_UNUSED_A : KIND_UNUSED_B;
			else if (pick < w_push)
				k = $urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
			else if (pick < w_push + w_pop)
				k = $urandom_range(1) ? KIND_POP_FRONT : KIND_POP_BACK;
			else if (pick < w_push + w_pop + w_purge)
				k = KIND_PURGE;
			else
				k = KIND_SIZE;
			if ($urandom_range(1))
				v = hot_bytes[2'($urandom_range(3))];
			else
				v = VAL_W'($urandom_range(255));
			send_beat(k, v);
			if (k <= KIND_SIZE)
				sent++;
		end
	endtask

	initial begin
		set_idling(0);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		wait_drained();
		// push-heavy: runs into the full deque and refused pushes
		run_mix(320, 92, 4, 0, 4);
		wait_drained();
		run_mix(200, 30, 30, 15, 10);
		wait_drained();
		// pop-heavy: drains to empty and pops past it
		run_mix(230, 4, 88, 4, 4);
		wait_drained();
		repeat (SETTLE_TICKS) @(posedge clk);
		$display("%0d commands accepted, %0d results checked under four idling mixes",
			cmds_seen, results_seen);
		$display("%0d pushes refused when full, %0d pops on empty, %0d bytes purged",
			full_drops, empty_pops, bytes_purged);
		if (fails == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/bdq_pkg.sv
hdl/byte_deque_with_purge.sv
sim/bdq_checker.sv
sim/testbench.sv
